// ===== hdl/mbd_pkg.sv =====
// Package for the 2x2 box-filter mipmap downsampler.
// Holds widths, register indexes, the queue command type and the channel arithmetic.
// No dependencies; every other file of the block but mbd_ram uses it.
package mbd_pkg;

  localparam int unsigned MAX_OUT_WIDTH  = 2048;
  localparam int unsigned MAX_OUT_HEIGHT = 2048;

  localparam int unsigned DIM_W     = 12;
  localparam int unsigned PIX_W     = 32;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned NUM_CH    = 4;
  localparam int unsigned PSUM_W    = CH_W + 1;
  localparam int unsigned SUM_W     = NUM_CH * PSUM_W;
  localparam int unsigned SLOT_W    = $clog2(MAX_OUT_WIDTH);
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = CFG_IDX_W'(1);

  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [SUM_W-1:0]  psum_t;
  typedef logic [SLOT_W-1:0] slot_t;

  // One unit of work for the back end.
  typedef struct packed {
    logic  rd;     // 1: complete a block against the line store, 0: fill the line store
    slot_t slot;
    psum_t sum;
    logic  last;
  } cmd_t;

  // Clamp a size register and return the last source coordinate, 2*size-1.
  function automatic dim_t src_last(dim_t v, int unsigned lim);
    dim_t              eff;
    logic [DIM_W:0]    dbl;
    eff = v;
    if (v == '0) eff = DIM_W'(1);
    if (int'(v) > int'(lim)) eff = DIM_W'(lim);
    dbl = {eff, 1'b0} - (DIM_W + 1)'(1);
    return dbl[DIM_W-1:0];
  endfunction

  // Four 9-bit channel sums of two pixels.
  function automatic psum_t pair_sum(pix_t a, pix_t b);
    psum_t s;
    for (int c = 0; c < int'(NUM_CH); c++) begin
      s[c*PSUM_W +: PSUM_W] = PSUM_W'(a[c*CH_W +: CH_W]) + PSUM_W'(b[c*CH_W +: CH_W]);
    end
    return s;
  endfunction

  // Add two rows of pair sums and divide each channel by four.
  function automatic pix_t box_avg(psum_t s, psum_t t);
    pix_t            r;
    logic [PSUM_W:0] v;
    for (int c = 0; c < int'(NUM_CH); c++) begin
      v = (PSUM_W + 1)'(s[c*PSUM_W +: PSUM_W]) + (PSUM_W + 1)'(t[c*PSUM_W +: PSUM_W]);
      r[c*CH_W +: CH_W] = v[PSUM_W:2];
    end
    return r;
  endfunction

endpackage

// ===== hdl/mbd_if.sv =====
// Channel interfaces of the downsampler: source pixels, results, register writes.
// Depends on mbd_pkg.
interface mbd_in_if;
  logic          valid;
  logic          ready;
  mbd_pkg::pix_t source_pixel;
  modport source (output valid, output source_pixel, input ready);
  modport sink (input valid, input source_pixel, output ready);
endinterface

interface mbd_out_if;
  logic          valid;
  logic          ready;
  mbd_pkg::pix_t out_pixel;
  logic          frame_last;
  modport source (output valid, output out_pixel, output frame_last, input ready);
  modport sink (input valid, input out_pixel, input frame_last, output ready);
endinterface

interface mbd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mbd_pkg::CFG_IDX_W-1:0]      index;
  mbd_pkg::dim_t                      data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/mbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mbd_front.sv =====
// Front end: register port, source position counters, horizontal pairing.
// Depends on mbd_pkg and mbd_if; pushes commands into the queue.
module mbd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  mbd_in_if.sink        src,
  mbd_cfg_if.sink       cfg,
  input  logic          q_full_i,
  output logic          push_o,
  output mbd_pkg::cmd_t cmd_o
);

  mbd_pkg::dim_t last_col_q, last_col_d;
  mbd_pkg::dim_t last_row_q, last_row_d;
  mbd_pkg::dim_t col_q, col_d;
  mbd_pkg::dim_t row_q, row_d;
  mbd_pkg::pix_t first_q;
  logic          acc;
  logic          restart;

  assign cfg.ready = 1'b1;
  assign src.ready = !q_full_i;
  assign acc       = src.valid && !q_full_i;

  always_comb begin
    last_col_d = last_col_q;
    last_row_d = last_row_q;
    restart    = 1'b0;
    if (cfg.valid) begin
      unique case (cfg.index)
        mbd_pkg::REG_OUT_WIDTH: begin
          last_col_d = mbd_pkg::src_last(cfg.data, mbd_pkg::MAX_OUT_WIDTH);
          restart    = 1'b1;
        end
        mbd_pkg::REG_OUT_HEIGHT: begin
          last_row_d = mbd_pkg::src_last(cfg.data, mbd_pkg::MAX_OUT_HEIGHT);
          restart    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Advance the raster position, wrap at line and frame end; a size write restarts it at 0,0.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
    end else if (acc) begin
      if (col_q == last_col_q) begin
        col_d = '0;
        row_d = (row_q == last_row_q) ? '0 : row_q + mbd_pkg::DIM_W'(1);
      end else begin
        col_d = col_q + mbd_pkg::DIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= mbd_pkg::DIM_W'(1);
      last_row_q <= mbd_pkg::DIM_W'(1);
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      last_col_q <= last_col_d;
      last_row_q <= last_row_d;
      col_q      <= col_d;
      row_q      <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && !col_q[0]) begin
      first_q <= src.source_pixel;
    end
  end

  // Only the right pixel of a pair makes work for the back end.
  assign push_o     = acc && col_q[0];
  assign cmd_o.rd   = row_q[0];
  assign cmd_o.slot = col_q[mbd_pkg::SLOT_W:1];
  assign cmd_o.sum  = mbd_pkg::pair_sum(first_q, src.source_pixel);
  assign cmd_o.last = (row_q == last_row_q) && (col_q == last_col_q);

endmodule

// ===== hdl/mbd_fifo.sv =====
// Short command queue between front and back end.
// Depends on mbd_pkg.
module mbd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mbd_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output mbd_pkg::cmd_t data_o,
  output logic          empty_o
);

  localparam int unsigned PTR_W = $clog2(mbd_pkg::FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(mbd_pkg::FIFO_DEPTH + 1);

  mbd_pkg::cmd_t    mem_q [mbd_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [PTR_W-1:0] inc(logic [PTR_W-1:0] p);
    return (int'(p) == int'(mbd_pkg::FIFO_DEPTH) - 1) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == CNT_W'(mbd_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? inc(wr_q) : wr_q;
    rd_d  = pop_i ? inc(rd_q) : rd_q;
    cnt_d = cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/mbd_back.sv =====
// Back end: line store, vertical completion and the output register.
// Depends on mbd_pkg, mbd_if and mbd_ram.
module mbd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mbd_pkg::cmd_t cmd_i,
  input  logic          empty_i,
  output logic          pop_o,
  mbd_out_if.source     res
);

  logic            rd_vld_q, rd_vld_d;
  mbd_pkg::psum_t  rd_sum_q;
  logic            rd_last_q;
  logic            out_vld_q, out_vld_d;
  mbd_pkg::pix_t   out_pix_q;
  logic            out_last_q;
  mbd_pkg::psum_t  line_rdata;
  logic            out_free;
  logic            rd_adv;
  logic            we;
  logic            re;

  assign out_free = !out_vld_q || res.ready;
  assign rd_adv   = !rd_vld_q || out_free;
  assign pop_o    = !empty_i && rd_adv;
  assign we       = pop_o && !cmd_i.rd;
  assign re       = pop_o && cmd_i.rd;

  mbd_ram #(
    .WIDTH(mbd_pkg::SUM_W),
    .DEPTH(mbd_pkg::MAX_OUT_WIDTH)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cmd_i.slot),
    .wdata_i(cmd_i.sum),
    .re_i   (re),
    .raddr_i(cmd_i.slot),
    .rdata_o(line_rdata)
  );

  assign rd_vld_d  = rd_adv ? re : rd_vld_q;
  assign out_vld_d = out_free ? rd_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rd_sum_q  <= cmd_i.sum;
      rd_last_q <= cmd_i.last;
    end
    if (out_free && rd_vld_q) begin
      out_pix_q  <= mbd_pkg::box_avg(rd_sum_q, line_rdata);
      out_last_q <= rd_last_q;
    end
  end

  assign res.valid      = out_vld_q;
  assign res.out_pixel  = out_pix_q;
  assign res.frame_last = out_last_q;

endmodule

// ===== hdl/mipmap_box_downsample_core.sv =====
// 2x2 box-filter mipmap downsampler, top level.
// Path: a block's last source pixel passes the command queue, the line store read stage and the output register.
// Throughput: one source pixel per cycle while the queue is not full; set by one line store access per pixel pair.
// Reset: position counters clear, sizes go to 1x1, queue and output register empty.
// The line store is not cleared: an odd row only reads slots its even row just wrote.
// Depends on mbd_pkg, mbd_if, mbd_ram, mbd_front, mbd_fifo and mbd_back.
module mipmap_box_downsample_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  mbd_in_if.sink    src_i,
  mbd_cfg_if.sink   cfg_i,
  mbd_out_if.source res_o
);

  // Front: counts columns and rows, pairs each even pixel with the odd one after it,
  // and turns every pair into a command: fill the line store on even rows,
  // complete a block on odd rows.
  mbd_pkg::cmd_t push_cmd;
  logic          push;
  logic          q_full;

  // Back: pops commands, reads or writes the line store, and holds each result
  // in an output register so a stalled sink never blocks the source side directly.
  mbd_pkg::cmd_t pop_cmd;
  logic          pop;
  logic          q_empty;

  mbd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .src     (src_i),
    .cfg     (cfg_i),
    .q_full_i(q_full),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  // Two commands of slack: enough to push and pop in the same cycle at full rate.
  mbd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .data_o (pop_cmd),
    .empty_o(q_empty)
  );

  mbd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (pop_cmd),
    .empty_i(q_empty),
    .pop_o  (pop),
    .res    (res_o)
  );

endmodule

// ===== hdl/mbd_checker.sv =====
// Port-level checks for the downsampler, attached to the top level by bind.
// Depends on mipmap_box_downsample_core and mbd_pkg.
module mbd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          src_ready_i,
  input logic          res_valid_i,
  input logic          res_ready_i,
  input mbd_pkg::pix_t res_pixel_i,
  input logic          res_last_i,
  input logic          cfg_valid_i,
  input logic          cfg_ready_i
);

  // Hold a stalled result.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_pixel_i) && $stable(res_last_i))
    else $error("result changed while stalled");

  // Take register writes at once.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("register write not taken");

  // Drive known handshake outputs out of reset.
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(res_valid_i) && !$isunknown(src_ready_i))
    else $error("unknown handshake output");

  // Show a known frame mark with every result.
  a_last_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !$isunknown(res_last_i))
    else $error("unknown frame mark");

endmodule

bind mipmap_box_downsample_core mbd_checker u_mbd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .src_ready_i(src_i.ready),
  .res_valid_i(res_o.valid),
  .res_ready_i(res_o.ready),
  .res_pixel_i(res_o.out_pixel),
  .res_last_i (res_o.frame_last),
  .cfg_valid_i(cfg_i.valid),
  .cfg_ready_i(cfg_i.ready)
);
